>>> rtl/ultrasonic_ranging_controller_macros.svh
// Assertion helpers used by the port checker file.
`ifndef ULTRASONIC_RANGING_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGING_CONTROLLER_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define URC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while in reset.
`define URC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/urc_pkg.sv
package urc_pkg;

  localparam int WIDTH_COUNT_BITS = 16;
  localparam int PERIOD_BITS      = 24;
  localparam int TRIG_BITS        = 8;
  localparam int SHIFT_BITS       = 3;
  localparam int US_BITS          = 16;
  localparam int CM_BITS          = 11;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_TICKS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER_TICKS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TICK_SHIFT    = 2'd2;

  localparam logic [PERIOD_BITS-1:0] PERIOD_TICKS_RST  = 24'd128000;
  localparam logic [TRIG_BITS-1:0]   TRIGGER_TICKS_RST = 8'd20;
  localparam logic [SHIFT_BITS-1:0]  TICK_SHIFT_RST    = 3'd1;

  localparam int CM_DIVISOR = 58;
  // floor(x / 58) == (x * 36158) >> 21 for every 16-bit x
  localparam int CM_RECIP_BITS  = 16;
  localparam logic [CM_RECIP_BITS-1:0] CM_RECIP = 16'd36158;
  localparam int CM_RECIP_SHIFT = 21;
  localparam int CM_PROD_BITS   = US_BITS + CM_RECIP_BITS;

  typedef struct packed {
    logic                 trigger_level;
    logic                 measure_valid;
    logic [US_BITS-1:0]   echo_us;
    logic [CM_BITS-1:0]   distance_cm;
    logic                 timeout_seen;
  } result_t;

endpackage

>>> rtl/ultrasonic_ranging_controller.sv
// Ultrasonic ranging controller. One input transfer per base tick carries the sampled
// echo level; each one yields exactly one result transfer, registered and presented
// on the cycle after the input transfer. A new tick is taken every clock while the
// result register is empty or being drained, so the sustained rate is one tick per
// cycle, set by the single result register. Echo width is counted in ticks,
// saturating, then shifted by tick_shift into microseconds; centimetres come from
// a reciprocal multiply by 1/58. Configuration is written through cfg_we/cfg_index/
// cfg_wdata; index 3 is ignored.
module ultrasonic_ranging_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [urc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [urc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_echo_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_trigger_level,
  output logic                              out_measure_valid,
  output logic [urc_pkg::US_BITS-1:0]       out_echo_us,
  output logic [urc_pkg::CM_BITS-1:0]       out_distance_cm,
  output logic                              out_timeout_seen
);

  localparam int WCB = urc_pkg::WIDTH_COUNT_BITS;
  localparam logic [WCB-1:0] US_MAX = WCB'((64'd1 << urc_pkg::US_BITS) - 64'd1);

  logic [urc_pkg::PERIOD_BITS-1:0] period_ticks_r;
  logic [urc_pkg::TRIG_BITS-1:0]   trigger_ticks_r;
  logic [urc_pkg::SHIFT_BITS-1:0]  tick_shift_r;

  logic [urc_pkg::PERIOD_BITS-1:0] period_count_r, period_count_nxt;
  logic [urc_pkg::TRIG_BITS-1:0]   trigger_count_r, trigger_count_nxt;
  logic [WCB-1:0]                  width_count_r, width_count_nxt;
  logic                            echo_prev_r;
  logic                            busy_r, busy_nxt;
  logic                            bad_r, bad_nxt;

  logic                            out_valid_r;
  urc_pkg::result_t                res_r, res_nxt;

  logic                            in_xfer;
  logic [urc_pkg::PERIOD_BITS:0]   period_inc;
  logic                            wrap;
  logic                            rise;
  logic                            fall;
  logic [WCB-1:0]                  shifted;
  logic [urc_pkg::US_BITS-1:0]     us_val;
  logic [urc_pkg::CM_PROD_BITS-1:0] cm_prod;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r  <= urc_pkg::PERIOD_TICKS_RST;
      trigger_ticks_r <= urc_pkg::TRIGGER_TICKS_RST;
      tick_shift_r    <= urc_pkg::TICK_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urc_pkg::REG_PERIOD_TICKS:  period_ticks_r  <= cfg_wdata;
        urc_pkg::REG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[urc_pkg::TRIG_BITS-1:0];
        urc_pkg::REG_TICK_SHIFT:    tick_shift_r    <= cfg_wdata[urc_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    period_inc        = {1'b0, period_count_r} + 1'b1;
    wrap              = period_inc >= {1'b0, period_ticks_r};
    period_count_nxt  = wrap ? '0 : period_inc[urc_pkg::PERIOD_BITS-1:0];
    trigger_count_nxt = trigger_count_r;
    bad_nxt           = bad_r;
    busy_nxt          = busy_r;
    width_count_nxt   = width_count_r;
    res_nxt           = '0;

    if (wrap) begin
      if (busy_r) begin
        bad_nxt              = 1'b1;
        res_nxt.timeout_seen = 1'b1;
      end else begin
        trigger_count_nxt = trigger_ticks_r;
      end
    end

    res_nxt.trigger_level = (trigger_count_nxt != '0);
    if (trigger_count_nxt != '0) begin
      trigger_count_nxt = trigger_count_nxt - 1'b1;
    end

    rise = in_echo_level && !echo_prev_r;
    fall = !in_echo_level && echo_prev_r;

    if (rise) begin
      if (!busy_r) begin
        width_count_nxt = '0;
        busy_nxt        = 1'b1;
      end
    end else if (busy_r) begin
      if (width_count_r != '1) begin
        width_count_nxt = width_count_r + 1'b1;
      end
    end

    shifted = width_count_nxt >> tick_shift_r;
    us_val  = (shifted > US_MAX) ? '1 : urc_pkg::US_BITS'(shifted);
    cm_prod = urc_pkg::CM_PROD_BITS'(us_val) * urc_pkg::CM_PROD_BITS'(urc_pkg::CM_RECIP);

    if (!rise && busy_r && fall) begin
      if (!bad_nxt) begin
        res_nxt.measure_valid = 1'b1;
        res_nxt.echo_us       = us_val;
        res_nxt.distance_cm   = cm_prod[urc_pkg::CM_RECIP_SHIFT +: urc_pkg::CM_BITS];
      end else begin
        bad_nxt = 1'b0;
      end
      busy_nxt = 1'b0;
    end
  end

  // measurement state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r  <= '0;
      trigger_count_r <= '0;
      width_count_r   <= '0;
      echo_prev_r     <= 1'b0;
      busy_r          <= 1'b0;
      bad_r           <= 1'b0;
    end else if (in_xfer) begin
      period_count_r  <= period_count_nxt;
      trigger_count_r <= trigger_count_nxt;
      width_count_r   <= width_count_nxt;
      echo_prev_r     <= in_echo_level;
      busy_r          <= busy_nxt;
      bad_r           <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = res_r.trigger_level;
  assign out_measure_valid = res_r.measure_valid;
  assign out_echo_us       = res_r.echo_us;
  assign out_distance_cm   = res_r.distance_cm;
  assign out_timeout_seen  = res_r.timeout_seen;

endmodule

>>> rtl/urc_checker.sv
`include "ultrasonic_ranging_controller_macros.svh"

module urc_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_measure_valid,
  input logic [urc_pkg::US_BITS-1:0] out_echo_us,
  input logic [urc_pkg::CM_BITS-1:0] out_distance_cm
);

  logic [31:0]                   cm_lo;
  logic [31:0]                   cm_hi;
  logic [31:0]                   us_ext;
  logic                          in_xfer;
  logic                          idle_out;
  logic                          meas_out;
  logic                          stall;
  logic                          fields_zero;
  logic                          cm_ok;
  logic [urc_pkg::US_BITS:0]     held_bits;

  assign cm_lo       = 32'(out_distance_cm) * 32'(urc_pkg::CM_DIVISOR);
  assign cm_hi       = cm_lo + 32'(urc_pkg::CM_DIVISOR);
  assign us_ext      = 32'(out_echo_us);
  assign in_xfer     = in_valid && in_ready;
  assign idle_out    = out_valid && !out_measure_valid;
  assign meas_out    = out_valid && out_measure_valid;
  assign stall       = out_valid && !out_ready;
  assign fields_zero = (out_echo_us == '0) && (out_distance_cm == '0);
  assign cm_ok       = (cm_lo <= us_ext) && (us_ext < cm_hi);
  assign held_bits   = {out_measure_valid, out_echo_us};

  `URC_ASSERT_NEXT(a_result_follows, in_xfer, out_valid, "no result after input transfer")
  `URC_ASSERT_NOW(a_idle_fields_zero, idle_out, fields_zero, "fields set without measure_valid")
  `URC_ASSERT_NOW(a_cm_matches_us, meas_out, cm_ok, "distance_cm is not echo_us over 58")
  `URC_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(held_bits), "stalled result changed")

endmodule

bind ultrasonic_ranging_controller urc_port_checker u_urc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_measure_valid (out_measure_valid),
  .out_echo_us       (out_echo_us),
  .out_distance_cm   (out_distance_cm)
);

>>> bench/urc_checker.sv
`timescale 1ns / 100ps

module urc_checker
  import urc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_echo_level,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_trigger_level,
  input  logic                     out_measure_valid,
  input  logic [US_BITS-1:0]       out_echo_us,
  input  logic [CM_BITS-1:0]       out_distance_cm,
  input  logic                     out_timeout_seen,
  output int                       fail_count,
  output int                       pending,
  output int                       good_count,
  output int                       timeout_count
);

  logic [PERIOD_BITS-1:0]      period_reg;
  logic [TRIG_BITS-1:0]        trigger_reg;
  logic [SHIFT_BITS-1:0]       shift_reg;

  logic [PERIOD_BITS-1:0]      period_cnt;
  logic [TRIG_BITS-1:0]        pulse_cnt;
  logic [WIDTH_COUNT_BITS-1:0] echo_width;
  logic                        echo_last;
  logic                        measuring;
  logic                        spoilt;

  result_t                     tick_results[$];
  int                          mismatches;
  int                          goods;
  int                          timeouts;

  function automatic result_t range_tick(input logic echo);
    logic [PERIOD_BITS:0] next_cnt;
    logic [31:0]          span;
    logic [US_BITS-1:0]   us;
    result_t              r;
    r = '0;
    next_cnt = {1'b0, period_cnt} + 1'b1;
    if (next_cnt >= {1'b0, period_reg}) begin
      period_cnt = '0;
      if (measuring) begin
        spoilt = 1'b1;
        r.timeout_seen = 1'b1;
      end else begin
        pulse_cnt = trigger_reg;
      end
    end else begin
      period_cnt = next_cnt[PERIOD_BITS-1:0];
    end

    r.trigger_level = (pulse_cnt != '0);
    if (pulse_cnt != '0) pulse_cnt = pulse_cnt - 1'b1;

    if (echo && !echo_last) begin
      if (!measuring) begin
        echo_width = '0;
        measuring = 1'b1;
      end
    end else if (measuring) begin
      if (echo_width != '1) echo_width = echo_width + 1'b1;
      if (!echo && echo_last) begin
        if (!spoilt) begin
          span = 32'(echo_width) >> shift_reg;
          if (span > 32'hFFFF) span = 32'hFFFF;
          us = span[US_BITS-1:0];
          r.measure_valid = 1'b1;
          r.echo_us = us;
          r.distance_cm = CM_BITS'(us / US_BITS'(CM_DIVISOR));
        end else begin
          spoilt = 1'b0;
        end
        measuring = 1'b0;
      end
    end
    echo_last = echo;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      period_reg  = PERIOD_TICKS_RST;
      trigger_reg = TRIGGER_TICKS_RST;
      shift_reg   = TICK_SHIFT_RST;
      period_cnt  = '0;
      pulse_cnt   = '0;
      echo_width  = '0;
      echo_last   = 1'b0;
      measuring   = 1'b0;
      spoilt      = 1'b0;
      tick_results.delete();
      mismatches  = 0;
      goods       = 0;
      timeouts    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_TICKS:  period_reg  = cfg_wdata[PERIOD_BITS-1:0];
          REG_TRIGGER_TICKS: trigger_reg = cfg_wdata[TRIG_BITS-1:0];
          REG_TICK_SHIFT:    shift_reg   = cfg_wdata[SHIFT_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (tick_results.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches++;
        end else begin
          want = tick_results.pop_front();
          if (out_trigger_level !== want.trigger_level) begin
            $error("trigger_level: expected %0d, actual %0d",
                   want.trigger_level, out_trigger_level);
            mismatches++;
          end
          if (out_measure_valid !== want.measure_valid) begin
            $error("measure_valid: expected %0d, actual %0d",
                   want.measure_valid, out_measure_valid);
            mismatches++;
          end
          if (out_echo_us !== want.echo_us) begin
            $error("echo_us: expected %0d, actual %0d", want.echo_us, out_echo_us);
            mismatches++;
          end
          if (out_distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, actual %0d",
                   want.distance_cm, out_distance_cm);
            mismatches++;
          end
          if (out_timeout_seen !== want.timeout_seen) begin
            $error("timeout_seen: expected %0d, actual %0d",
                   want.timeout_seen, out_timeout_seen);
            mismatches++;
          end
          if (want.measure_valid) goods++;
          if (want.timeout_seen) timeouts++;
        end
      end

      if (in_valid && in_ready) tick_results.push_back(range_tick(in_echo_level));
    end
    fail_count    <= mismatches;
    pending       <= tick_results.size();
    good_count    <= goods;
    timeout_count <= timeouts;
  end

endmodule

>>> bench/tb_ultrasonic_ranging_controller.sv
`timescale 1ns / 100ps

module tb_ultrasonic_ranging_controller;
  import urc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int          PHASE_TICKS = 90;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_echo_level;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_trigger_level;
  logic                     out_measure_valid;
  logic [US_BITS-1:0]       out_echo_us;
  logic [CM_BITS-1:0]       out_distance_cm;
  logic                     out_timeout_seen;

  int                       fail_count;
  int                       pending;
  int                       good_count;
  int                       timeout_count;

  int                       idle_pct;
  int                       stall_pct;
  int                       ticks_sent;
  int                       settings_done;
  int unsigned              cycle_count = 0;

  ultrasonic_ranging_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_measure_valid (out_measure_valid),
    .out_echo_us       (out_echo_us),
    .out_distance_cm   (out_distance_cm),
    .out_timeout_seen  (out_timeout_seen)
  );

  urc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_measure_valid (out_measure_valid),
    .out_echo_us       (out_echo_us),
    .out_distance_cm   (out_distance_cm),
    .out_timeout_seen  (out_timeout_seen),
    .fail_count        (fail_count),
    .pending           (pending),
    .good_count        (good_count),
    .timeout_count     (timeout_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic echo);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_echo_level <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // let every outstanding result transfer out, then a few spare cycles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [PERIOD_BITS-1:0] period,
                               input logic [TRIG_BITS-1:0] trig,
                               input logic [SHIFT_BITS-1:0] shift);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PERIOD_TICKS;
    cfg_wdata <= CFG_DATA_BITS'(period);
    @(posedge clk);
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_wdata <= CFG_DATA_BITS'(trig);
    @(posedge clk);
    cfg_index <= REG_TICK_SHIFT;
    cfg_wdata <= CFG_DATA_BITS'(shift);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 53; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 53; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int len);
    for (int i = len - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  // mostly clean echo pulses of random spacing and width, some noise
  task automatic random_phase(input logic [PERIOD_BITS-1:0] period,
                              input logic [TRIG_BITS-1:0] trig,
                              input logic [SHIFT_BITS-1:0] shift, input int mode);
    int stop_at;
    load_settings(period, trig, shift);
    set_idling(mode);
    stop_at = ticks_sent + PHASE_TICKS;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(1, 24)) send_tick(1'b0);
        repeat ($urandom_range(1, 70)) send_tick(1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
      end
    end
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PERIOD_TICKS;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_echo_level <= 1'b0;
    ticks_sent    = 0;
    settings_done = 0;
    set_idling(0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one pulse measured with the default shift
    send_pattern(32'b01111100, 8);
    drain();

    // short period: trigger, clean pulse, then a stuck echo timing out
    load_settings(24'd8, 8'd3, 3'd0);
    send_pattern(32'b0000000011100111111111100, 25);
    drain();

    random_phase(24'd40, 8'd5, 3'd0, 0);
    random_phase(24'd1, 8'd1, 3'd4, 1);
    random_phase(24'd200, 8'd255, 3'd2, 2);
    random_phase(24'd0, 8'd0, 3'd7, 3);
    random_phase(24'hFFFFFF, 8'd1, 3'd3, 1);
    // period that may lie below the running count
    random_phase(24'd120, 8'd20, 3'd1, 2);
    random_phase(24'd64, 8'd7, 3'd4, 3);

    $display("Sent %0d echo ticks over %0d register settings, with and without idling",
             ticks_sent, settings_done);
    $display("Results held %0d good measurements and %0d timeouts",
             good_count, timeout_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
